// ----- rtl/sfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    // Default size of the payload store, in bytes.
    localparam int MAX_PAYLOAD_DEF = 32;

    // Header bytes of a frame.
    localparam logic [7:0] HDR_A = 8'hB5;
    localparam logic [7:0] HDR_B = 8'h5B;

    // Shortest legal length byte: type byte plus check byte.
    localparam logic [7:0] LEN_MIN = 8'h02;

    // Frame type codes.
    localparam logic [7:0] TYPE_ALL    = 8'h02;
    localparam logic [7:0] TYPE_ENEMY  = 8'h03;
    localparam logic [7:0] TYPE_OWN    = 8'h04;
    localparam logic [7:0] TYPE_STATUS = 8'h07;

    // Record kinds on the output.
    localparam logic [1:0] KIND_ALL    = 2'd0;
    localparam logic [1:0] KIND_ENEMY  = 2'd1;
    localparam logic [1:0] KIND_OWN    = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // A status frame carries five payload bytes.
    localparam int STATUS_BYTES = 5;

    // Hand-over from the parser to the emitter when a frame closes.
    typedef struct packed {
        logic       start;
        logic       is_status;
        logic [1:0] kind;
    } t_frame_done;

endpackage

`default_nettype wire

// ----- rtl/sfd_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfd_store #(
    parameter int DEPTH = sfd_pkg::MAX_PAYLOAD_DEF,
    parameter int AW    = $clog2(sfd_pkg::MAX_PAYLOAD_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port, used by the parser while payload bytes arrive.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, used by the emitter; data appears in the cycle after i_rd_en.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/sfd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfd_parser #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF,
    parameter int AW          = $clog2(sfd_pkg::MAX_PAYLOAD_DEF),
    parameter int CW          = $clog2(sfd_pkg::MAX_PAYLOAD_DEF + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_byte,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [7:0]                o_wr_data,
    output sfd_pkg::t_frame_done      o_done,
    output logic [CW-1:0]             o_count
);

    localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD + 2);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ARMED,
        PH_LEN,
        PH_TYPE,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [7:0]    r_len, n_len;
    logic [7:0]    r_type, n_type;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] pos_inc;

    assign pos_inc = r_pos + CW'(1);

    // Next state of the byte parser and the frame hand-over.
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_type  = r_type;
        n_pos   = r_pos;
        o_wr_en = 1'b0;
        o_done  = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    n_phase = (i_byte == sfd_pkg::HDR_A) ? PH_ARMED : PH_HUNT;
                end
                PH_ARMED: begin
                    if (i_byte == sfd_pkg::HDR_B) begin
                        n_phase = PH_LEN;
                    end else if (i_byte == sfd_pkg::HDR_A) begin
                        n_phase = PH_ARMED;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN: begin
                    if (i_byte < sfd_pkg::LEN_MIN || i_byte > LEN_MAX) begin
                        n_phase = (i_byte == sfd_pkg::HDR_A) ? PH_ARMED : PH_HUNT;
                    end else begin
                        n_len   = i_byte;
                        n_pos   = '0;
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_type  = i_byte;
                    n_phase = (r_len > sfd_pkg::LEN_MIN) ? PH_PAYLOAD : PH_CHECK;
                end
                PH_PAYLOAD: begin
                    o_wr_en = 1'b1;
                    n_pos   = pos_inc;
                    if ((9'(pos_inc) + 9'd2) >= {1'b0, r_len}) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    // The check byte itself is not examined; the frame closes here.
                    n_phase = PH_HUNT;
                    case (r_type)
                        sfd_pkg::TYPE_ALL: begin
                            o_done.start = 1'b1;
                            o_done.kind  = sfd_pkg::KIND_ALL;
                        end
                        sfd_pkg::TYPE_ENEMY: begin
                            o_done.start = 1'b1;
                            o_done.kind  = sfd_pkg::KIND_ENEMY;
                        end
                        sfd_pkg::TYPE_OWN: begin
                            o_done.start = 1'b1;
                            o_done.kind  = sfd_pkg::KIND_OWN;
                        end
                        sfd_pkg::TYPE_STATUS: begin
                            // A status frame too short to fill the record is dropped.
                            if (r_pos >= CW'(sfd_pkg::STATUS_BYTES)) begin
                                o_done.start     = 1'b1;
                                o_done.is_status = 1'b1;
                                o_done.kind      = sfd_pkg::KIND_STATUS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_type  <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_type  <= n_type;
            r_pos   <= n_pos;
        end
    end

    assign o_wr_addr = r_pos[AW-1:0];
    assign o_wr_data = i_byte;
    assign o_count   = r_pos;

endmodule

`default_nettype wire

// ----- rtl/sfd_emitter.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfd_emitter #(
    parameter int AW = $clog2(sfd_pkg::MAX_PAYLOAD_DEF),
    parameter int CW = $clog2(sfd_pkg::MAX_PAYLOAD_DEF + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sfd_pkg::t_frame_done i_done,
    input  wire logic [CW-1:0]        i_count,
    output logic                      o_busy,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr,
    input  wire logic [7:0]           i_rd_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [1:0]                o_record_kind,
    output logic [5:0]                o_list_count,
    output logic [4:0]                o_elem_index,
    output logic [7:0]                o_elem_value,
    output logic [7:0]                o_target_health,
    output logic [7:0]                o_own_health,
    output logic [7:0]                o_hit_count,
    output logic [7:0]                o_shot_count,
    output logic [7:0]                o_ammo_left,
    output logic                      o_last
);

    localparam int CW1 = CW + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_LOAD,
        ST_SHOW
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic          r_is_status;
    logic [1:0]    r_kind;
    logic [5:0]    r_list_count;
    logic [4:0]    r_elem_index;
    logic [7:0]    r_elem_value;
    logic [7:0]    r_status [sfd_pkg::STATUS_BYTES];
    logic          r_last;
    logic          idx_is_final;

    // The element just read closes the list.
    assign idx_is_final = (CW1'(r_idx) + CW1'(1)) == CW1'(r_count);

    // Drain sequencer: read entry into result word, show it; status reads all five.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_done.start) begin
                        r_idx        <= '0;
                        r_count      <= i_count;
                        r_is_status  <= i_done.is_status;
                        r_kind       <= i_done.kind;
                        r_list_count <= i_done.is_status ? 6'd0 : 6'(i_count);
                        r_elem_index <= '0;
                        r_elem_value <= '0;
                        for (int k = 0; k < sfd_pkg::STATUS_BYTES; k++) begin
                            r_status[k] <= '0;
                        end
                        // An empty list gives a single word straight away.
                        if (!i_done.is_status && i_count == '0) begin
                            r_last  <= 1'b1;
                            r_state <= ST_SHOW;
                        end else begin
                            r_last  <= 1'b0;
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (r_is_status) begin
                        for (int k = 0; k < sfd_pkg::STATUS_BYTES; k++) begin
                            if (r_idx == AW'(k)) begin
                                r_status[k] <= i_rd_data;
                            end
                        end
                        if (r_idx == AW'(sfd_pkg::STATUS_BYTES - 1)) begin
                            r_last  <= 1'b1;
                            r_state <= ST_SHOW;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= ST_ISSUE;
                        end
                    end else begin
                        r_elem_value <= i_rd_data;
                        r_elem_index <= 5'(r_idx);
                        r_last       <= idx_is_final;
                        r_state      <= ST_SHOW;
                    end
                end
                ST_SHOW: begin
                    if (!i_stall) begin
                        if (r_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_rd_en         = (r_state == ST_ISSUE);
    assign o_rd_addr       = r_idx;
    assign o_valid         = (r_state == ST_SHOW);
    assign o_record_kind   = r_kind;
    assign o_list_count    = r_list_count;
    assign o_elem_index    = r_elem_index;
    assign o_elem_value    = r_elem_value;
    assign o_target_health = r_status[0];
    assign o_own_health    = r_status[1];
    assign o_hit_count     = r_status[2];
    assign o_shot_count    = r_status[3];
    assign o_ammo_left     = r_status[4];
    assign o_last          = r_last;

endmodule

`default_nettype wire

// ----- rtl/serial_frame_deframer_unit.sv -----
// Serial frame deframer. Received bytes enter one per word on the input channel; the
// parser takes a byte in the cycle it is offered, hunting for the header B5 5B, then a
// length byte, a type byte, the payload and a check byte, and writes payload bytes into
// a synchronous store of MAX_PAYLOAD entries. When the check byte of a list frame
// (types 02, 03, 04) or of a full status frame (type 07) arrives, the input stalls while
// the emitter drains the store through its single read port: a list element passes
// through address, read-data and output-word states, plus any output stall, and a
// status record reads its five bytes one at a time. An empty list gives its word in
// the next cycle. Bytes that cause no result never stall the input. No clearing pass
// follows reset: every store entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_deframer_unit #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_record_kind,
    output logic [5:0]      o_list_count,
    output logic [4:0]      o_elem_index,
    output logic [7:0]      o_elem_value,
    output logic [7:0]      o_target_health,
    output logic [7:0]      o_own_health,
    output logic [7:0]      o_hit_count,
    output logic [7:0]      o_shot_count,
    output logic [7:0]      o_ammo_left,
    output logic            o_last
);

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    sfd_pkg::t_frame_done done;
    logic [CW-1:0]        count;
    logic                 busy;
    logic                 accept;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [7:0]           rd_data;

    // The input is held off while a frame's results are being drained.
    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    sfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW),
        .CW          (CW)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_rx_byte),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_done    (done),
        .o_count   (count)
    );

    sfd_store #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sfd_emitter #(
        .AW (AW),
        .CW (CW)
    ) u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_done          (done),
        .i_count         (count),
        .o_busy          (busy),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_record_kind   (o_record_kind),
        .o_list_count    (o_list_count),
        .o_elem_index    (o_elem_index),
        .o_elem_value    (o_elem_value),
        .o_target_health (o_target_health),
        .o_own_health    (o_own_health),
        .o_hit_count     (o_hit_count),
        .o_shot_count    (o_shot_count),
        .o_ammo_left     (o_ammo_left),
        .o_last          (o_last)
    );

`ifndef ASSERT_OFF
    // No byte is taken while a result word is on offer.
    a_no_accept_while_showing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !o_valid)
        else $error("input byte accepted while a result word is pending");

    // The final word of a frame ends the run.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> !o_valid)
        else $error("result word offered after the final word of a frame");

    // A status record is always a run of one word.
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_kind == sfd_pkg::KIND_STATUS) |-> o_last)
        else $error("status record not marked as final word");

    // The store is never written while it is being drained.
    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !wr_en)
        else $error("payload store written during drain");
`endif

endmodule

`default_nettype wire
